// ----- rtl/spt_pkg.sv -----
`timescale 1ns / 1ps

package spt_pkg;

   localparam int NUM_SLOTS      = 8;
   localparam int VALUE_BITS     = 16;
   localparam int INTERVAL_BITS  = 16;
   localparam int SLOT_BITS      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int MAX_RESULTS    = 8;
   localparam int COUNT_BITS     = $clog2(MAX_RESULTS + 1);
   localparam int OUT_SLOT_BITS  = 3;
   localparam int WIDE_SLOT_BITS = SLOT_BITS + OUT_SLOT_BITS;
   localparam int REQ_DATA_BITS  = 72;
   localparam int RSP_DATA_BITS  = 8;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);

   localparam logic [1:0] SENSOR_LEVEL    = 2'd0;
   localparam logic [1:0] SENSOR_MOISTURE = 2'd1;

   localparam logic [1:0] TRIG_ABOVE = 2'd0;
   localparam logic [1:0] TRIG_BELOW = 2'd1;
   localparam logic [1:0] TRIG_CROSS = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_ENABLE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ADDED   = 3'd0,
      KIND_FULL    = 3'd1,
      KIND_ENABLED = 3'd2,
      KIND_MESSAGE = 3'd3,
      KIND_NO_MSG  = 3'd4
   } kind_type;

   typedef struct packed {
      cmd_type                  command;
      logic [1:0]               sensor_type;
      logic [INTERVAL_BITS-1:0] interval;
      logic [1:0]               trigger;
      logic [VALUE_BITS-1:0]    threshold;
      logic                     enable;
      logic [VALUE_BITS-1:0]    level;
      logic [VALUE_BITS-1:0]    moisture;
   } req_type;

   typedef struct packed {
      logic [INTERVAL_BITS-1:0] interval;
      logic                     enabled;
      logic [INTERVAL_BITS-1:0] elapsed;
      logic [1:0]               kind;
      logic [1:0]               trigger;
      logic [VALUE_BITS-1:0]    threshold;
      logic [VALUE_BITS-1:0]    value;
   } slot_type;

   typedef struct packed {
      logic wr;
      logic hit;
      logic fire;
   } step_type;

   typedef struct packed {
      kind_type                 kind;
      logic [1:0]               sensor_type;
      logic [1:0]               trigger;
      logic [OUT_SLOT_BITS-1:0] slot;
   } result_type;

   function automatic logic [OUT_SLOT_BITS-1:0] to_out_slot(input logic [SLOT_BITS-1:0] s);
      logic [WIDE_SLOT_BITS-1:0] w;
      w = WIDE_SLOT_BITS'(s);
      return w[OUT_SLOT_BITS-1:0];
   endfunction

endpackage

// ----- rtl/spt_table.sv -----
`timescale 1ns / 1ps

module spt_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [spt_pkg::SLOT_BITS-1:0]   idx,
   input  logic                            wr_en,
   input  spt_pkg::slot_type               wr_slot,
   output spt_pkg::slot_type               rd_slot
);

   logic [spt_pkg::INTERVAL_BITS-1:0] interval_ff [spt_pkg::NUM_SLOTS];
   logic                              enabled_ff  [spt_pkg::NUM_SLOTS];
   spt_pkg::slot_type                 data_ff     [spt_pkg::NUM_SLOTS];

   // interval and enable reset; remaining fields only read after an add writes them
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spt_pkg::NUM_SLOTS; i++) begin
            interval_ff[i] <= '0;
            enabled_ff[i]  <= 1'b0;
         end
      end else if (wr_en) begin
         interval_ff[idx] <= wr_slot.interval;
         enabled_ff[idx]  <= wr_slot.enabled;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_ff[idx] <= wr_slot;
      end
   end

   always_comb begin
      rd_slot          = data_ff[idx];
      rd_slot.interval = interval_ff[idx];
      rd_slot.enabled  = enabled_ff[idx];
   end

endmodule

// ----- rtl/spt_alu.sv -----
`timescale 1ns / 1ps

module spt_alu (
   input  spt_pkg::req_type  req,
   input  spt_pkg::slot_type cur,
   output spt_pkg::slot_type nxt,
   output spt_pkg::step_type step
);

   logic [spt_pkg::INTERVAL_BITS-1:0] elapsed_inc;
   logic [spt_pkg::VALUE_BITS-1:0]    sample;
   logic                              used;
   logic                              was_above;
   logic                              now_above;
   logic                              hit_cond;

   always_comb begin
      elapsed_inc = cur.elapsed + spt_pkg::INTERVAL_BITS'(1);
      used        = (cur.interval != '0);
      was_above   = (cur.value >= cur.threshold);
      sample      = cur.value;
      if (cur.kind == spt_pkg::SENSOR_LEVEL) begin
         sample = req.level;
      end else if (cur.kind == spt_pkg::SENSOR_MOISTURE) begin
         sample = req.moisture;
      end
      now_above = (sample >= cur.threshold);

      unique case (cur.trigger)
         spt_pkg::TRIG_ABOVE: hit_cond = now_above;
         spt_pkg::TRIG_BELOW: hit_cond = !now_above;
         spt_pkg::TRIG_CROSS: hit_cond = (now_above != was_above);
         default:             hit_cond = 1'b0;
      endcase

      nxt  = cur;
      step = '0;
      unique case (req.command)
         spt_pkg::CMD_TICK: begin
            if (cur.enabled && used) begin
               step.wr = 1'b1;
               if (elapsed_inc < cur.interval) begin
                  nxt.elapsed = elapsed_inc;
               end else begin
                  nxt.elapsed = '0;
                  nxt.value   = sample;
                  step.fire   = hit_cond;
               end
            end
         end
         spt_pkg::CMD_ADD: begin
            if (!used) begin
               step.wr       = 1'b1;
               step.hit      = 1'b1;
               nxt.kind      = req.sensor_type;
               nxt.interval  = req.interval;
               nxt.trigger   = req.trigger;
               nxt.threshold = req.threshold;
               nxt.enabled   = 1'b0;
               nxt.elapsed   = '0;
               nxt.value     = '0;
            end
         end
         spt_pkg::CMD_ENABLE: begin
            if (used && (cur.kind == req.sensor_type)) begin
               step.wr     = 1'b1;
               nxt.enabled = req.enable;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/sensor_poll_threshold_trigger.sv -----
`timescale 1ns / 1ps

// Sensor slot table with per-slot poll intervals and threshold triggers. One word is
// taken at a time; a sequencer then walks the slot table one slot per cycle (unless
// the scan pauses) through a single shared update unit (increment, interval compare,
// threshold compares). A tick or an enable visits every slot, an add stops at the
// first free slot, and command 3 is dropped with no result. A tick returns one
// message word per firing slot in slot order (at most eight, tlast on the final one)
// or a single no-message word; every other command returns one word.
// The scan pauses only when a slot fires while a message is already held and the
// output register is still occupied, and the final word waits for the output
// register, so backpressure only slows it.
module sensor_poll_threshold_trigger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sensor_type, poll_interval, trigger_mode, threshold, enable_flag,
   // level_reading, moisture_reading, zero fill
   input  logic [spt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // command
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // msg_sensor_type, msg_trigger, slot_index, zero fill
   output logic [spt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // kind
   output logic [2:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                          state_ff,      state_in;
   spt_pkg::req_type                   req_ff,        req_in;
   logic [spt_pkg::SLOT_BITS-1:0]      idx_ff,        idx_in;
   logic [spt_pkg::COUNT_BITS-1:0]     count_ff,      count_in;
   spt_pkg::result_type                pend_ff,       pend_in;
   logic                               pend_valid_ff, pend_valid_in;
   spt_pkg::result_type                rsp_ff,        rsp_in;
   logic                               rsp_valid_ff,  rsp_valid_in;
   logic                               rsp_last_ff,   rsp_last_in;

   spt_pkg::slot_type                  cur_slot;
   spt_pkg::slot_type                  nxt_slot;
   spt_pkg::step_type                  step;
   logic                               tbl_wr;
   logic                               out_free;
   logic                               report;
   logic                               advance;
   spt_pkg::kind_type                  done_kind;

   spt_table u_table (
      .clock   (clock),
      .reset   (reset),
      .idx     (idx_ff),
      .wr_en   (tbl_wr),
      .wr_slot (nxt_slot),
      .rd_slot (cur_slot)
   );

   spt_alu u_alu (
      .req  (req_ff),
      .cur  (cur_slot),
      .nxt  (nxt_slot),
      .step (step)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign report     = step.fire && (count_ff < spt_pkg::COUNT_BITS'(spt_pkg::MAX_RESULTS));
   // a second report needs the output register to take the held one
   assign advance    = !(report && pend_valid_ff && !out_free);

   always_comb begin
      unique case (req_ff.command)
         spt_pkg::CMD_ADD:    done_kind = spt_pkg::KIND_FULL;
         spt_pkg::CMD_ENABLE: done_kind = spt_pkg::KIND_ENABLED;
         default:             done_kind = spt_pkg::KIND_NO_MSG;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      tbl_wr        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               req_in.command     = spt_pkg::cmd_type'(req_tuser);
               req_in.sensor_type = req_tdata[1:0];
               req_in.interval    = spt_pkg::INTERVAL_BITS'(req_tdata[17:2]);
               req_in.trigger     = req_tdata[19:18];
               req_in.threshold   = spt_pkg::VALUE_BITS'(req_tdata[35:20]);
               req_in.enable      = req_tdata[36];
               req_in.level       = spt_pkg::VALUE_BITS'(req_tdata[52:37]);
               req_in.moisture    = spt_pkg::VALUE_BITS'(req_tdata[68:53]);
               idx_in             = '0;
               count_in           = '0;
               pend_valid_in      = 1'b0;
               if (spt_pkg::cmd_type'(req_tuser) != spt_pkg::CMD_NONE) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (advance) begin
               tbl_wr = step.wr;
               if (report) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in.kind        = spt_pkg::KIND_MESSAGE;
                  pend_in.sensor_type = cur_slot.kind;
                  pend_in.trigger     = cur_slot.trigger;
                  pend_in.slot        = spt_pkg::to_out_slot(idx_ff);
                  pend_valid_in       = 1'b1;
                  count_in            = count_ff + spt_pkg::COUNT_BITS'(1);
               end
               if (step.hit) begin
                  pend_in.kind        = spt_pkg::KIND_ADDED;
                  pend_in.sensor_type = nxt_slot.kind;
                  pend_in.trigger     = nxt_slot.trigger;
                  pend_in.slot        = spt_pkg::to_out_slot(idx_ff);
                  pend_valid_in       = 1'b1;
                  state_in            = ST_DONE;
               end else if (idx_ff == spt_pkg::LAST_SLOT) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + spt_pkg::SLOT_BITS'(1);
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = pend_ff;
               end else begin
                  rsp_in      = '0;
                  rsp_in.kind = done_kind;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      count_ff    <= count_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.slot, rsp_ff.trigger, rsp_ff.sensor_type};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

endmodule
